// File: sv/nsbs_pkg.sv
// Shared constants, codes and helper functions for the nameserver back-off selector.
package nsbs_pkg;

   localparam int MaxServers  = 4;
   localparam int AddrRegs    = 4;
   localparam int Limit       = (MaxServers < AddrRegs) ? MaxServers : AddrRegs;
   localparam int PhaseDigits = 5;   // phase kept as base-3 digits, 3^5 = 243

   localparam logic [1:0] CmdSelect  = 2'd0;
   localparam logic [1:0] CmdTimeout = 2'd1;
   localparam logic [1:0] CmdReply   = 2'd2;

   localparam logic [2:0] RegServerCount = 3'd0;
   localparam logic [2:0] RegServerAddr0 = 3'd1;
   localparam logic [2:0] RegServerAddr1 = 3'd2;
   localparam logic [2:0] RegServerAddr2 = 3'd3;
   localparam logic [2:0] RegServerAddr3 = 3'd4;

   localparam logic [7:0] CountMax = 8'hFF;

   // x mod 3 by summing base-4 digits (4 == 1 mod 3)
   function automatic logic [1:0] mod3_8(input logic [7:0] x);
      logic [3:0] s;
      logic [2:0] t;
      s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
      t = 3'(s[1:0]) + 3'(s[3:2]);
      if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

   // number of low ternary digits that must be zero for a given timeout count
   function automatic logic [2:0] period_digits(input logic [7:0] cnt);
      logic [2:0] k;
      if (cnt >= 8'd5) begin
         k = 3'd5;
      end else begin
         k = cnt[2:0];
      end
      return k;
   endfunction

endpackage

// File: sv/nameserver_backoff_select.sv
// Nameserver back-off selector: server choice, timeout counting and reply source matching.
//
// One transaction is accepted per clock cycle while req_stall is low; each produces exactly
// one result in the rsp_ output register. All selection, matching and count updates happen
// in a single pass of combinational logic between the request handshake and that register.
// A two-entry output stage (output register plus skid register) lets a request be taken
// while a result is stalled; req_stall rises only once both entries hold results. The send
// phase is held as five base-3 digits so the 3^count period tests are plain zero checks.
// Configuration writes (csr_index 0: server_count, 1..4: server address/port) must be made
// while the block is idle.
module nameserver_backoff_select (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_send_count,
   input  logic [3:0]  req_send_ok_mask,
   input  logic [1:0]  req_server_index,
   input  logic [31:0] req_source_addr,
   input  logic [15:0] req_source_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_chosen_server,
   output logic        rsp_send_failed,
   output logic        rsp_reply_trusted,
   output logic [1:0]  rsp_reply_server
);

   typedef struct packed {
      logic [1:0] chosen_server;
      logic       send_failed;
      logic       reply_trusted;
      logic [1:0] reply_server;
   } result_type;

   logic [2:0]  server_count_ff;
   logic [47:0] server_addr_ff [nsbs_pkg::AddrRegs];
   logic [7:0]  count_ff [nsbs_pkg::MaxServers];
   logic [7:0]  count_in [nsbs_pkg::MaxServers];
   logic [1:0]  phase_ff [nsbs_pkg::PhaseDigits];
   logic [1:0]  phase_in [nsbs_pkg::PhaseDigits];

   result_type  out_ff, out_in;
   result_type  skid_ff, skid_in;
   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;

   result_type  result;
   logic        accept;
   logic [2:0]  n_eff;
   logic [1:0]  start;
   logic [5:0]  zero_upto;     // zero_upto[k]: low k phase digits are all zero
   logic [3:0]  elig1, elig2;
   logic        found1, found2;
   logic [1:0]  pick1, pick2;
   logic        match_hit;
   logic [1:0]  match_idx;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;

   assign rsp_valid         = out_valid_ff;
   assign rsp_chosen_server = out_ff.chosen_server;
   assign rsp_send_failed   = out_ff.send_failed;
   assign rsp_reply_trusted = out_ff.reply_trusted;
   assign rsp_reply_server  = out_ff.reply_server;

   // effective server count, saturated to the number of slots
   always_comb begin
      if (server_count_ff > 3'(nsbs_pkg::Limit)) begin
         n_eff = 3'(nsbs_pkg::Limit);
      end else begin
         n_eff = server_count_ff;
      end
   end

   // scan start: (send_count - 1) mod n
   always_comb begin
      logic [1:0] m;
      m = nsbs_pkg::mod3_8(req_send_count);
      case (n_eff)
         3'd2:    start = {1'b0, ~req_send_count[0]};
         3'd3:    start = (m == 2'd0) ? 2'd2 : ((m == 2'd1) ? 2'd0 : 2'd1);
         3'd4:    start = req_send_count[1:0] - 2'd1;
         default: start = 2'd0;
      endcase
   end

   // ternary phase increment; 22222 + 1 wraps to 00000 (mod 243)
   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int j = 0; j < nsbs_pkg::PhaseDigits; j++) begin
         phase_in[j] = phase_ff[j];
         if (carry) begin
            if (phase_ff[j] == 2'd2) begin
               phase_in[j] = 2'd0;
            end else begin
               phase_in[j] = phase_ff[j] + 2'd1;
               carry = 1'b0;
            end
         end
      end
   end

   always_comb begin
      zero_upto[0] = 1'b1;
      for (int j = 0; j < nsbs_pkg::PhaseDigits; j++) begin
         zero_upto[j+1] = zero_upto[j] && (phase_in[j] == 2'd0);
      end
   end

   // per-server eligibility for the normal pass and the retry pass
   always_comb begin
      elig1 = '0;
      elig2 = '0;
      for (int s = 0; s < nsbs_pkg::Limit; s++) begin
         elig1[s] = (3'(s) < n_eff) && req_send_ok_mask[s] &&
                    ((count_ff[s] == 8'd0) ||
                     zero_upto[nsbs_pkg::period_digits(count_ff[s])]);
         elig2[s] = (3'(s) < n_eff) && req_send_ok_mask[s] && (count_ff[s] != 8'd0);
      end
   end

   // rotated priority search starting at 'start', wrapping at n
   always_comb begin
      logic [2:0] pos;
      found1 = 1'b0;
      found2 = 1'b0;
      pick1  = 2'd0;
      pick2  = 2'd0;
      for (int i = 0; i < nsbs_pkg::MaxServers; i++) begin
         pos = 3'(start) + 3'(i);
         if (pos >= n_eff) begin
            pos = pos - n_eff;
         end
         if (3'(i) < n_eff) begin
            if (!found1 && elig1[pos[1:0]]) begin
               found1 = 1'b1;
               pick1  = pos[1:0];
            end
            if (!found2 && elig2[pos[1:0]]) begin
               found2 = 1'b1;
               pick2  = pos[1:0];
            end
         end
      end
   end

   // reply source match, first server wins; address zero is a wildcard
   always_comb begin
      logic [31:0] a;
      logic [15:0] p;
      match_hit = 1'b0;
      match_idx = 2'd0;
      for (int s = nsbs_pkg::AddrRegs - 1; s >= 0; s--) begin
         a = server_addr_ff[s][47:16];
         p = server_addr_ff[s][15:0];
         if ((3'(s) < n_eff) && (p == req_source_port) &&
             ((a == 32'd0) || (a == req_source_addr))) begin
            match_hit = 1'b1;
            match_idx = 2'(s);
         end
      end
   end

   always_comb begin
      result = '0;
      case (req_command)
         nsbs_pkg::CmdSelect: begin
            if (found1) begin
               result.chosen_server = pick1;
            end else if (found2) begin
               result.chosen_server = pick2;
            end else begin
               result.send_failed = 1'b1;
            end
         end
         nsbs_pkg::CmdReply: begin
            result.reply_trusted = match_hit;
            result.reply_server  = match_hit ? match_idx : 2'd0;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_comb begin
      for (int s = 0; s < nsbs_pkg::MaxServers; s++) begin
         count_in[s] = count_ff[s];
         if (accept && (s < nsbs_pkg::Limit)) begin
            if ((req_command == nsbs_pkg::CmdTimeout) &&
                (req_server_index == 2'(s)) && (count_ff[s] != nsbs_pkg::CountMax)) begin
               count_in[s] = count_ff[s] + 8'd1;
            end
            if ((req_command == nsbs_pkg::CmdReply) && match_hit && (match_idx == 2'(s))) begin
               count_in[s] = 8'd0;
            end
         end
      end
   end

   // output register with skid entry behind it
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         server_count_ff <= 3'd1;
         for (int s = 0; s < nsbs_pkg::AddrRegs; s++) begin
            server_addr_ff[s] <= '0;
         end
         for (int s = 0; s < nsbs_pkg::MaxServers; s++) begin
            count_ff[s] <= '0;
         end
         for (int j = 0; j < nsbs_pkg::PhaseDigits; j++) begin
            phase_ff[j] <= '0;
         end
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         for (int s = 0; s < nsbs_pkg::MaxServers; s++) begin
            count_ff[s] <= count_in[s];
         end
         if (accept && (req_command == nsbs_pkg::CmdSelect)) begin
            for (int j = 0; j < nsbs_pkg::PhaseDigits; j++) begin
               phase_ff[j] <= phase_in[j];
            end
         end
         if (csr_write) begin
            case (csr_index)
               nsbs_pkg::RegServerCount: server_count_ff <= csr_data[2:0];
               nsbs_pkg::RegServerAddr0: server_addr_ff[0] <= csr_data;
               nsbs_pkg::RegServerAddr1: server_addr_ff[1] <= csr_data;
               nsbs_pkg::RegServerAddr2: server_addr_ff[2] <= csr_data;
               nsbs_pkg::RegServerAddr3: server_addr_ff[3] <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// File: tb/tb_nameserver_backoff_select.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nameserver back-off selector: directed and random traffic.
module tb_nameserver_backoff_select;

   localparam logic [1:0] CmdUnknown = 2'd3;
   localparam int PhaseWrap     = 243;
   localparam int IdlePct       = 28;
   localparam int PhaseItems    = 160;
   localparam int DeepItems     = 420;
   localparam int WatchdogLimit = 5000;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  send_count;
      logic [3:0]  ok_mask;
      logic [1:0]  server_index;
      logic [31:0] source_addr;
      logic [15:0] source_port;
   } ns_query_type;

   typedef struct packed {
      logic [1:0] chosen;
      logic       failed;
      logic       trusted;
      logic [1:0] reply_srv;
   } ns_verdict_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [47:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic [7:0]  req_send_count;
   logic [3:0]  req_send_ok_mask;
   logic [1:0]  req_server_index;
   logic [31:0] req_source_addr;
   logic [15:0] req_source_port;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_chosen_server;
   logic        rsp_send_failed;
   logic        rsp_reply_trusted;
   logic [1:0]  rsp_reply_server;

   bit             idle_on = 1'b1;
   int             mismatches = 0;
   int             quiet_cycles = 0;
   ns_verdict_type verdict_q[$];

   // shadow copy of the block's state and registers
   logic [7:0]  timeout_cnt [nsbs_pkg::MaxServers];
   logic [7:0]  phase_now;
   logic [2:0]  server_cnt;
   logic [47:0] server_addr [nsbs_pkg::AddrRegs];

   nameserver_backoff_select dut (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < IdlePct);
   end

   function automatic int backoff_period(input logic [7:0] cnt);
      case (cnt)
         8'd1: return 3;
         8'd2: return 9;
         8'd3: return 27;
         8'd4: return 81;
         default: return PhaseWrap;
      endcase
   endfunction

   function automatic void clear_shadow();
      foreach (timeout_cnt[i]) timeout_cnt[i] = '0;
      foreach (server_addr[i]) server_addr[i] = '0;
      phase_now  = '0;
      server_cnt = 3'd1;
   endfunction

   function automatic ns_verdict_type predict_verdict(input ns_query_type q);
      ns_verdict_type v;
      int             n;
      int             start;
      int             s;
      int             ph;
      bit             found;
      v = '0;
      found = 1'b0;
      n = (server_cnt > nsbs_pkg::Limit) ? nsbs_pkg::Limit : server_cnt;
      case (q.command)
         nsbs_pkg::CmdSelect: begin
            ph = (int'(phase_now) + 1) % PhaseWrap;
            phase_now = 8'(ph);
            if (n > 0) begin
               start = (int'(q.send_count) + n - 1) % n;
               // first pass: healthy servers, plus failing ones whose back-off window is open
               for (int i = 0; i < n && !found; i++) begin
                  s = (start + i) % n;
                  if (timeout_cnt[s] != 0 && (ph % backoff_period(timeout_cnt[s])) != 0)
                     continue;
                  if (q.ok_mask[s]) begin
                     found = 1'b1;
                     v.chosen = 2'(s);
                  end
               end
               for (int i = 0; i < n && !found; i++) begin
                  s = (start + i) % n;
                  if (timeout_cnt[s] == 0)
                     continue;
                  if (q.ok_mask[s]) begin
                     found = 1'b1;
                     v.chosen = 2'(s);
                  end
               end
            end
            v.failed = !found;
         end
         nsbs_pkg::CmdTimeout: begin
            if (q.server_index < nsbs_pkg::Limit &&
                timeout_cnt[q.server_index] != nsbs_pkg::CountMax)
               timeout_cnt[q.server_index] = timeout_cnt[q.server_index] + 8'd1;
         end
         nsbs_pkg::CmdReply: begin
            for (s = 0; s < n && !found; s++) begin
               if (server_addr[s][15:0] == q.source_port &&
                   (server_addr[s][47:16] == 32'd0 ||
                    server_addr[s][47:16] == q.source_addr)) begin
                  found = 1'b1;
                  timeout_cnt[s] = '0;
                  v.trusted = 1'b1;
                  v.reply_srv = 2'(s);
               end
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      ns_verdict_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected result expected none actual %0d/%0d/%0d/%0d", $time,
                        rsp_chosen_server, rsp_send_failed, rsp_reply_trusted,
                        rsp_reply_server);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               check_field("chosen_server", want.chosen, rsp_chosen_server);
               check_field("send_failed", want.failed, rsp_send_failed);
               check_field("reply_trusted", want.trusted, rsp_reply_trusted);
               check_field("reply_server", want.reply_srv, rsp_reply_server);
            end
         end
         if (req_valid && !req_stall)
            verdict_q.push_back(predict_verdict({req_command, req_send_count, req_send_ok_mask,
                                                 req_server_index, req_source_addr,
                                                 req_source_port}));
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: watchdog expired with %0d results outstanding", $time,
                  verdict_q.size());
         $display("nameserver_backoff_select: mismatch");
         $finish;
      end
   end

   function automatic ns_query_type query(input logic [1:0] cmd, input logic [7:0] cnt,
                                          input logic [3:0] mask, input logic [1:0] idx,
                                          input logic [31:0] addr, input logic [15:0] port);
      return '{cmd, cnt, mask, idx, addr, port};
   endfunction

   // called at a falling edge; returns at the falling edge after the transaction is taken
   task automatic send_query(input ns_query_type q);
      if (idle_on) begin
         while ($urandom_range(99) < IdlePct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_command      <= q.command;
      req_send_count   <= q.send_count;
      req_send_ok_mask <= q.ok_mask;
      req_server_index <= q.server_index;
      req_source_addr  <= q.source_addr;
      req_source_port  <= q.source_port;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
      if (idx == nsbs_pkg::RegServerCount)
         server_cnt = data[2:0];
      else if (idx <= nsbs_pkg::RegServerAddr3)
         server_addr[idx - nsbs_pkg::RegServerAddr0] = data;
   endtask

   function automatic ns_query_type random_query(input int sel_pct, input int tmo_pct,
                                                 input int rep_pct);
      ns_query_type q;
      int           roll;
      int           s;
      q = '{2'd0, 8'($urandom_range(255)), 4'($urandom_range(15)), 2'($urandom_range(3)),
            $urandom(), 16'($urandom_range(65535))};
      roll = $urandom_range(99);
      if (roll < sel_pct)
         q.command = nsbs_pkg::CmdSelect;
      else if (roll < sel_pct + tmo_pct)
         q.command = nsbs_pkg::CmdTimeout;
      else if (roll < sel_pct + tmo_pct + rep_pct)
         q.command = nsbs_pkg::CmdReply;
      else
         q.command = CmdUnknown;
      // most replies aim at a configured server, some with a corrupted address
      if (q.command == nsbs_pkg::CmdReply && $urandom_range(99) < 70) begin
         s = $urandom_range(nsbs_pkg::AddrRegs - 1);
         q.source_port = server_addr[s][15:0];
         if (server_addr[s][47:16] != 32'd0)
            q.source_addr = server_addr[s][47:16];
         if ($urandom_range(9) == 0)
            q.source_addr ^= 32'd1 << $urandom_range(31);
      end
      return q;
   endfunction

   task automatic random_setup();
      logic [47:0] a;
      int          roll;
      roll = $urandom_range(9);
      if (roll < 8)
         write_reg(nsbs_pkg::RegServerCount, 48'($urandom_range(4, 1)));
      else if (roll == 8)
         write_reg(nsbs_pkg::RegServerCount, 48'd0);
      else
         write_reg(nsbs_pkg::RegServerCount, 48'($urandom_range(7, 5)));
      for (int s = 0; s < nsbs_pkg::AddrRegs; s++) begin
         a[15:0]  = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
         a[47:16] = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
         write_reg(3'(nsbs_pkg::RegServerAddr0 + s), a);
      end
   endtask

   // defaults after reset: one server, wildcard address, port 0
   task automatic test_power_on();
      send_query(query(nsbs_pkg::CmdSelect, 8'd1, 4'b0001, 2'd0, 32'd0, 16'd0));
      send_query(query(nsbs_pkg::CmdSelect, 8'd255, 4'b0000, 2'd3, 32'hFFFF_FFFF, 16'hFFFF));
      send_query(query(nsbs_pkg::CmdReply, 8'd0, 4'b1111, 2'd0, 32'h1234_5678, 16'd0));
      send_query(query(nsbs_pkg::CmdReply, 8'hFF, 4'b0000, 2'd3, 32'hFFFF_FFFF, 16'hFFFF));
      send_query(query(CmdUnknown, 8'hFF, 4'b1111, 2'd3, 32'hFFFF_FFFF, 16'hFFFF));
   endtask

   task automatic test_config_extremes();
      settle();
      write_reg(nsbs_pkg::RegServerCount, 48'd0);
      send_query(query(nsbs_pkg::CmdSelect, 8'd1, 4'b1111, 2'd0, 32'd0, 16'd0));
      send_query(query(nsbs_pkg::CmdReply, 8'd1, 4'b1111, 2'd0, 32'h0A00_0001, 16'd0));
      send_query(query(nsbs_pkg::CmdTimeout, 8'd1, 4'b0000, 2'd2, 32'd0, 16'd0));
      settle();
      write_reg(nsbs_pkg::RegServerCount, 48'd7);   // saturates to four servers
      write_reg(nsbs_pkg::RegServerAddr0, 48'hFFFF_FFFF_FFFF);
      write_reg(nsbs_pkg::RegServerAddr1, {32'd0, 16'hFFFF});
      write_reg(nsbs_pkg::RegServerAddr2, {32'h0A00_0001, 16'd53});
      write_reg(nsbs_pkg::RegServerAddr3, {32'd0, 16'd53});
      send_query(query(nsbs_pkg::CmdReply, 8'd0, 4'b0000, 2'd0, 32'hFFFF_FFFF, 16'hFFFF));
      send_query(query(nsbs_pkg::CmdReply, 8'd0, 4'b0000, 2'd0, 32'd0, 16'hFFFF));
      send_query(query(nsbs_pkg::CmdReply, 8'd0, 4'b0000, 2'd0, 32'h0A00_0001, 16'd53));
      send_query(query(nsbs_pkg::CmdReply, 8'd0, 4'b0000, 2'd0, 32'h0A00_0002, 16'd53));
      send_query(query(nsbs_pkg::CmdSelect, 8'd4, 4'b1000, 2'd0, 32'd0, 16'd0));
   endtask

   task automatic test_start_rotation();
      send_query(query(nsbs_pkg::CmdSelect, 8'd0, 4'b1111, 2'd0, 32'd0, 16'd0));   // wraps
      send_query(query(nsbs_pkg::CmdSelect, 8'd2, 4'b0100, 2'd0, 32'd0, 16'd0));
      send_query(query(nsbs_pkg::CmdSelect, 8'd3, 4'b0001, 2'd0, 32'd0, 16'd0));
   endtask

   task automatic test_backoff_and_recovery();
      send_query(query(nsbs_pkg::CmdTimeout, 8'd0, 4'b0000, 2'd1, 32'd0, 16'd0));
      send_query(query(nsbs_pkg::CmdTimeout, 8'd0, 4'b0000, 2'd1, 32'd0, 16'd0));
      send_query(query(nsbs_pkg::CmdTimeout, 8'd0, 4'b0000, 2'd3, 32'd0, 16'd0));
      send_query(query(nsbs_pkg::CmdSelect, 8'd2, 4'b0010, 2'd0, 32'd0, 16'd0));
      send_query(query(nsbs_pkg::CmdSelect, 8'd4, 4'b1010, 2'd0, 32'd0, 16'd0));
      send_query(query(nsbs_pkg::CmdReply, 8'd0, 4'b0000, 2'd0, 32'h0000_0001, 16'hFFFF));
      send_query(query(nsbs_pkg::CmdSelect, 8'd2, 4'b0010, 2'd0, 32'd0, 16'd0));
      send_query(query(nsbs_pkg::CmdTimeout, 8'd0, 4'b0000, 2'd0, 32'd0, 16'd0));
   endtask

   task automatic test_random_traffic(input int phases, input int quiet_phase);
      for (int ph = 0; ph < phases; ph++) begin
         settle();
         random_setup();
         idle_on <= (ph != quiet_phase);
         repeat (PhaseItems) send_query(random_query(45, 25, 25));
      end
      idle_on <= 1'b1;
   endtask

   // long timeout runs on one server to drive its count into saturation
   task automatic test_deep_backoff();
      ns_query_type q;
      settle();
      write_reg(nsbs_pkg::RegServerCount, 48'd4);
      repeat (DeepItems) begin
         q = random_query(12, 88, 0);
         if (q.command == nsbs_pkg::CmdTimeout && $urandom_range(3) != 0)
            q.server_index = 2'd3;
         send_query(q);
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write        = 1'b0;
      csr_index        = nsbs_pkg::RegServerCount;
      csr_data         = '0;
      req_valid        = 1'b0;
      req_command      = nsbs_pkg::CmdSelect;
      req_send_count   = '0;
      req_send_ok_mask = '0;
      req_server_index = '0;
      req_source_addr  = '0;
      req_source_port  = '0;
      clear_shadow();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_on();
      test_config_extremes();
      test_start_rotation();
      test_backoff_and_recovery();
      test_random_traffic(3, 2);
      test_deep_backoff();
      test_random_traffic(2, -1);

      settle();
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("nameserver_backoff_select: match");
      end else begin
         $display("nameserver_backoff_select: mismatch");
      end
      $finish;
   end

endmodule
